[hw/rtl/wmmd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmmd_pkg
// Shared types and constants of the waveform min/max decimator: request and
// response words, the push bundle into the output queue, register indexes.
// ----------------------------------------------------------------------------
package wmmd_pkg;

   // widths and limits
   localparam int unsigned SAMPLE_BITS = 16;
   localparam int unsigned FRAME_BITS  = 24;
   localparam logic [12:0] MAX_COLUMNS = 13'd4096;
   localparam logic [31:0] SPP_ONE     = 32'd65536;

   // register indexes on the write port
   typedef enum logic [1:0] {
      CSR_SPP     = 2'd0,
      CSR_SCROLL  = 2'd1,
      CSR_COLUMNS = 2'd2,
      CSR_STEREO  = 2'd3
   } csr_index_type;

   // one stereo frame
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_sample;
      logic signed [SAMPLE_BITS-1:0] right_sample;
      logic                          final_frame;
   } req_word_type;

   // one column result
   typedef struct packed {
      logic [11:0]                   column;
      logic [12:0]                   span;
      logic signed [SAMPLE_BITS-1:0] left_min;
      logic [SAMPLE_BITS-2:0]        left_max;
      logic signed [SAMPLE_BITS-1:0] right_min;
      logic [SAMPLE_BITS-2:0]        right_max;
      logic                          last_of_run;
   } rsp_word_type;

   // up to two result words pushed by one frame
   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type first;
      rsp_word_type second;
   } push_type;

endpackage

[hw/rtl/wmmd_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmmd_tracker
// Control registers and column state. Takes one frame per step, updates the
// running min/max and column boundary, and hands out zero to two result words.
// ----------------------------------------------------------------------------
module wmmd_tracker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  wmmd_pkg::csr_index_type   csr_index,
   input  logic [31:0]               csr_write_data,
   input  logic                      step,
   input  wmmd_pkg::req_word_type    word,
   output wmmd_pkg::push_type        push
);

   localparam logic [24:0] FRAME_MAX = '1;

   // spp below one frame counts as one frame
   function automatic logic [31:0] eff_spp(input logic [31:0] s);
      logic [31:0] r;
      r = s;
      if (s < wmmd_pkg::SPP_ONE) r = wmmd_pkg::SPP_ONE;
      return r;
   endfunction

   // column count clamped to one .. MAX_COLUMNS
   function automatic logic [12:0] eff_cols(input logic [12:0] c);
      logic [12:0] r;
      r = c;
      if (c == 13'd0) r = 13'd1;
      else if (c > wmmd_pkg::MAX_COLUMNS) r = wmmd_pkg::MAX_COLUMNS;
      return r;
   endfunction

   // control registers
   logic [31:0] spp_ff, spp_in;
   logic [23:0] scroll_ff, scroll_in;
   logic [12:0] cols_ff, cols_in;
   logic        stereo_ff, stereo_in;

   // column state
   logic [24:0] frame_ff, frame_in;
   logic [12:0] col_ff, col_in;
   logic [47:0] end_ff, end_in;
   logic signed [15:0] min0_ff, min0_in, min1_ff, min1_in;
   logic signed [15:0] max0_ff, max0_in, max1_ff, max1_in;
   logic        done_ff, done_in;

   // per-frame terms
   logic signed [15:0] l, r;
   logic signed [15:0] acc_min0, acc_max0, acc_min1, acc_max1;
   logic [31:0] spp_e;
   logic [12:0] cols_e, col_p1, col_after;
   logic [32:0] frame_p1;
   logic        active, close_col, done_after, fill;
   logic [44:0] cfg_prod;
   wmmd_pkg::rsp_word_type close_word, fill_word;

   assign spp_e  = eff_spp(spp_ff);
   assign cols_e = eff_cols(cols_ff);
   assign col_p1 = col_ff + 13'd1;

   // samples, right forced to zero in mono
   assign l = word.left_sample;
   assign r = stereo_ff ? word.right_sample : 16'sd0;

   // accumulate into the running extremes
   assign acc_min0 = (l < min0_ff) ? l : min0_ff;
   assign acc_max0 = (l > max0_ff) ? l : max0_ff;
   assign acc_min1 = (stereo_ff && (r < min1_ff)) ? r : min1_ff;
   assign acc_max1 = (stereo_ff && (r > max1_ff)) ? r : max1_ff;

   // column boundary check
   assign frame_p1   = {8'd0, frame_ff} + 33'd1;
   assign active     = !done_ff && (frame_ff >= {1'b0, scroll_ff});
   assign close_col  = active && (word.final_frame || (frame_p1 >= {1'b0, end_ff[47:16]}));
   assign done_after = done_ff || (close_col && (col_p1 >= cols_e));
   assign col_after  = close_col ? col_p1 : col_ff;
   assign fill       = word.final_frame && !done_after;

   // result words
   always_comb begin
      close_word.column      = col_ff[11:0];
      close_word.span        = 13'd1;
      close_word.left_min    = acc_min0;
      close_word.left_max    = acc_max0[14:0];
      close_word.right_min   = acc_min1;
      close_word.right_max   = acc_max1[14:0];
      close_word.last_of_run = !fill;

      fill_word.column       = col_after[11:0];
      fill_word.span         = cols_e - col_after;
      fill_word.left_min     = l[15] ? l : 16'sd0;
      fill_word.left_max     = (l > 16'sd0) ? l[14:0] : 15'd0;
      fill_word.right_min    = r[15] ? r : 16'sd0;
      fill_word.right_max    = (r > 16'sd0) ? r[14:0] : 15'd0;
      fill_word.last_of_run  = 1'b1;

      push.count  = 2'd0;
      push.first  = close_col ? close_word : fill_word;
      push.second = fill_word;
      if (step) begin
         push.count = {1'b0, close_col} + {1'b0, fill};
      end
   end

   // boundary recomputed from the new registers on a write
   assign cfg_prod = col_p1 * eff_spp(spp_in);

   // next state
   always_comb begin
      spp_in    = spp_ff;
      scroll_in = scroll_ff;
      cols_in   = cols_ff;
      stereo_in = stereo_ff;
      frame_in  = frame_ff;
      col_in    = col_ff;
      end_in    = end_ff;
      min0_in   = min0_ff;
      max0_in   = max0_ff;
      min1_in   = min1_ff;
      max1_in   = max1_ff;
      done_in   = done_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            wmmd_pkg::CSR_SPP:     spp_in    = csr_write_data;
            wmmd_pkg::CSR_SCROLL:  scroll_in = csr_write_data[23:0];
            wmmd_pkg::CSR_COLUMNS: cols_in   = csr_write_data[12:0];
            wmmd_pkg::CSR_STEREO:  stereo_in = csr_write_data[0];
         endcase
         done_in = done_ff || (col_ff >= eff_cols(cols_in));
         end_in  = {8'd0, scroll_in, 16'd0} + {3'd0, cfg_prod};
      end else if (step) begin
         if (word.final_frame) begin
            // restart for the next clip
            frame_in = 25'd0;
            col_in   = 13'd0;
            done_in  = 1'b0;
            min0_in  = 16'sd0;
            max0_in  = 16'sd0;
            min1_in  = 16'sd0;
            max1_in  = 16'sd0;
            end_in   = {8'd0, scroll_ff, 16'd0} + {16'd0, spp_e};
         end else begin
            if (frame_ff != FRAME_MAX) frame_in = frame_ff + 25'd1;
            if (close_col) begin
               col_in  = col_p1;
               done_in = done_after;
               end_in  = end_ff + {16'd0, spp_e};
               min0_in = 16'sd0;
               max0_in = 16'sd0;
               min1_in = 16'sd0;
               max1_in = 16'sd0;
            end else if (active) begin
               min0_in = acc_min0;
               max0_in = acc_max0;
               min1_in = acc_min1;
               max1_in = acc_max1;
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         spp_ff    <= wmmd_pkg::SPP_ONE;
         scroll_ff <= 24'd0;
         cols_ff   <= 13'd1024;
         stereo_ff <= 1'b1;
         frame_ff  <= 25'd0;
         col_ff    <= 13'd0;
         end_ff    <= {16'd0, wmmd_pkg::SPP_ONE};
         min0_ff   <= 16'sd0;
         max0_ff   <= 16'sd0;
         min1_ff   <= 16'sd0;
         max1_ff   <= 16'sd0;
         done_ff   <= 1'b0;
      end else begin
         spp_ff    <= spp_in;
         scroll_ff <= scroll_in;
         cols_ff   <= cols_in;
         stereo_ff <= stereo_in;
         frame_ff  <= frame_in;
         col_ff    <= col_in;
         end_ff    <= end_in;
         min0_ff   <= min0_in;
         max0_ff   <= max0_in;
         min1_ff   <= min1_in;
         max1_ff   <= max1_in;
         done_ff   <= done_in;
      end
   end

endmodule

[hw/rtl/wmmd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmmd_queue
// Four-word result queue. Takes up to two words per cycle and sends one word
// per cycle on the response channel while rsp_ready is high.
// ----------------------------------------------------------------------------
module wmmd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  wmmd_pkg::push_type     push,
   output logic                   room,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output wmmd_pkg::rsp_word_type rsp_word
);

   wmmd_pkg::rsp_word_type words_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_word  = words_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   // space for two words once this cycle's pop is counted
   assign room = (count_ff <= 3'd2) || ((count_ff == 3'd3) && pop);

   // pointer and fill level
   assign wr_ptr_in = wr_ptr_ff + push.count;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign count_in  = count_ff + {1'b0, push.count} - {2'd0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         words_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         words_ff[wr_ptr_ff + 2'd1] <= push.second;
      end
   end

endmodule

[hw/rtl/waveform_minmax_decimator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_minmax_decimator
// Min/max peak decimator for a stereo waveform display, one frame per word.
// ----------------------------------------------------------------------------
// A frame word is taken every cycle while the block is ready. It is held in an
// input register until the queue has room, then the column tracker updates the
// running extremes and the column boundary and pushes zero, one or two result
// words into a four-word output queue; the first result word passes through
// the input register and the queue storage before it is valid on the response
// side. The response side sends one word per cycle while rsp_ready is high,
// and frames are taken one per cycle while the queue has room; a frame that
// closes a column and also fills the rest of the view pushes two words. A
// register write with a new boundary uses one 13 by 32 bit multiply, and its
// result is registered with the other control registers.
// ----------------------------------------------------------------------------
module waveform_minmax_decimator (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  wmmd_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output wmmd_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write_enable,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_write_data
);

   logic                   in_valid_ff, in_valid_in;
   wmmd_pkg::req_word_type in_word_ff;
   logic                   advance;
   logic                   room;
   wmmd_pkg::push_type     push;

   // input register
   assign advance     = in_valid_ff && room;
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_word;
      end
   end

   // column tracker
   wmmd_tracker u_tracker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (wmmd_pkg::csr_index_type'(csr_index)),
      .csr_write_data   (csr_write_data),
      .step             (advance),
      .word             (in_word_ff),
      .push             (push)
   );

   // result queue
   wmmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // a held frame stays held until the queue has room
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("held frame lost from input register");

   // words are pushed only for a frame that is stepped, at most two
   assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (advance && push.count != 2'd3))
      else $error("bad push into result queue");

   // the first pushed word covers one to MAX_COLUMNS columns
   assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |->
         (push.first.span != 13'd0 && push.first.span <= wmmd_pkg::MAX_COLUMNS))
      else $error("result span out of range");

   // of two words from one frame only the second ends the run
   assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (!push.first.last_of_run && push.second.last_of_run))
      else $error("last_of_run misplaced");

endmodule

[tb/tb_waveform_minmax_decimator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_waveform_minmax_decimator
// Self-checking bench for the min/max peak decimator. A scoreboard class keeps
// its own copy of the view registers and the clip state, works out the column
// words each accepted frame should produce and compares every result word in
// order. Stimulus is a directed set of edge cases followed by random clips
// under random view settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_waveform_minmax_decimator;

   localparam int          DIRECTED_ITEMS = 25;
   localparam int          RANDOM_ITEMS   = 1300;
   localparam int          SETTLE_CYCLES  = 8;
   localparam int          HOLDOFF_CYCLES = 300;
   localparam int          CYCLE_LIMIT    = 200000;
   localparam logic [24:0] FRAME_LAST     = '1;

   // expected column words and the clip state behind them
   class minmax_scoreboard;
      logic [31:0]            spp_q16;
      logic [23:0]            scroll;
      logic [12:0]            columns;
      logic                   stereo;
      logic [24:0]            frame_index;
      logic [12:0]            column_now;
      logic [63:0]            column_end;
      logic signed [15:0]     low_seen [2];
      logic signed [15:0]     high_seen [2];
      bit                     view_done;
      wmmd_pkg::rsp_word_type expected_columns [$];
      int unsigned            mismatches;

      function new();
         spp_q16    = wmmd_pkg::SPP_ONE;
         scroll     = '0;
         columns    = 13'd1024;
         stereo     = 1'b1;
         mismatches = 0;
         restart_clip();
      endfunction

      function logic [31:0] spp_used();
         return (spp_q16 < wmmd_pkg::SPP_ONE) ? wmmd_pkg::SPP_ONE : spp_q16;
      endfunction

      function logic [12:0] columns_used();
         if (columns == 13'd0) return 13'd1;
         if (columns > wmmd_pkg::MAX_COLUMNS) return wmmd_pkg::MAX_COLUMNS;
         return columns;
      endfunction

      // 48.16 frame position where the open column ends
      function void set_column_end();
         column_end = {24'd0, scroll, 16'd0}
                      + (64'(column_now) + 64'd1) * 64'(spp_used());
      endfunction

      function void clear_extremes();
         low_seen[0]  = '0;
         low_seen[1]  = '0;
         high_seen[0] = '0;
         high_seen[1] = '0;
      endfunction

      function void restart_clip();
         frame_index = '0;
         column_now  = '0;
         view_done   = 1'b0;
         clear_extremes();
         set_column_end();
      endfunction

      function void apply_register(wmmd_pkg::csr_index_type idx, logic [31:0] data);
         case (idx)
            wmmd_pkg::CSR_SPP:     spp_q16 = data;
            wmmd_pkg::CSR_SCROLL:  scroll  = data[23:0];
            wmmd_pkg::CSR_COLUMNS: columns = data[12:0];
            wmmd_pkg::CSR_STEREO:  stereo  = data[0];
            default: ;
         endcase
         if (column_now >= columns_used()) view_done = 1'b1;
         set_column_end();
      endfunction

      // emit the open column and step on to the next
      function wmmd_pkg::rsp_word_type close_column();
         wmmd_pkg::rsp_word_type w;
         w.column      = column_now[11:0];
         w.span        = 13'd1;
         w.left_min    = low_seen[0];
         w.left_max    = high_seen[0][14:0];
         w.right_min   = low_seen[1];
         w.right_max   = high_seen[1][14:0];
         w.last_of_run = 1'b0;
         clear_extremes();
         column_now = column_now + 13'd1;
         if (column_now >= columns_used()) view_done = 1'b1;
         set_column_end();
         return w;
      endfunction

      function void note_frame(wmmd_pkg::req_word_type frame);
         logic signed [15:0]     l;
         logic signed [15:0]     r;
         wmmd_pkg::rsp_word_type words [2];
         int                     produced;
         l        = frame.left_sample;
         r        = stereo ? frame.right_sample : 16'sd0;
         produced = 0;
         // frames inside the view feed the open column
         if (!view_done && frame_index >= 25'(scroll)) begin
            if (l < low_seen[0])  low_seen[0]  = l;
            if (l > high_seen[0]) high_seen[0] = l;
            if (stereo) begin
               if (r < low_seen[1])  low_seen[1]  = r;
               if (r > high_seen[1]) high_seen[1] = r;
            end
            if (frame.final_frame || (64'(frame_index) + 64'd1) >= (column_end >> 16)) begin
               words[produced] = close_column();
               produced++;
            end
         end
         // end of clip: one fill word that spans every column left over
         if (frame.final_frame) begin
            if (!view_done) begin
               words[produced].column      = column_now[11:0];
               words[produced].span        = columns_used() - column_now;
               words[produced].left_min    = (l < 0) ? l : 16'sd0;
               words[produced].left_max    = (l > 0) ? l[14:0] : 15'd0;
               words[produced].right_min   = (r < 0) ? r : 16'sd0;
               words[produced].right_max   = (r > 0) ? r[14:0] : 15'd0;
               words[produced].last_of_run = 1'b0;
               produced++;
            end
            restart_clip();
         end else if (frame_index != FRAME_LAST) begin
            frame_index = frame_index + 25'd1;
         end
         if (produced > 0) words[produced-1].last_of_run = 1'b1;
         for (int i = 0; i < produced; i++) expected_columns.push_back(words[i]);
      endfunction

      function void check_column(wmmd_pkg::rsp_word_type got);
         wmmd_pkg::rsp_word_type want;
         bit                     bad;
         if (expected_columns.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected column word: col %0d span %0d l %0d/%0d r %0d/%0d last %0b",
                        got.column, got.span, got.left_min, got.left_max,
                        got.right_min, got.right_max, got.last_of_run);
            return;
         end
         want = expected_columns.pop_front();
         bad  = (got.column !== want.column) || (got.span !== want.span)
                || (got.left_min !== want.left_min) || (got.left_max !== want.left_max)
                || (got.right_min !== want.right_min) || (got.right_max !== want.right_max)
                || (got.last_of_run !== want.last_of_run);
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("column word mismatch at %0t", $time);
               $display("  exp: col %0d span %0d l %0d/%0d r %0d/%0d last %0b",
                        want.column, want.span, want.left_min, want.left_max,
                        want.right_min, want.right_max, want.last_of_run);
               $display("  got: col %0d span %0d l %0d/%0d r %0d/%0d last %0b",
                        got.column, got.span, got.left_min, got.left_max,
                        got.right_min, got.right_max, got.last_of_run);
            end
         end
      endfunction

      function int pending();
         return expected_columns.size();
      endfunction
   endclass

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   wmmd_pkg::req_word_type req_word         = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   wmmd_pkg::rsp_word_type rsp_word;
   logic                   csr_write_enable = 1'b0;
   logic [1:0]             csr_index        = '0;
   logic [31:0]            csr_write_data   = '0;

   minmax_scoreboard sb;
   int               items_sent     = 0;
   bit               steady         = 1'b0;
   int               holdoff_asked  = 0;
   int               holdoff_served = 0;
   int               holdoff_left   = 0;
   int               cycle_count    = 0;

   waveform_minmax_decimator uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // response side: random stalls, long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holdoff_left != 0) begin
         rsp_ready    <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else if (holdoff_served != holdoff_asked) begin
         rsp_ready      <= 1'b0;
         holdoff_served <= holdoff_served + 1;
         holdoff_left   <= HOLDOFF_CYCLES;
      end else begin
         rsp_ready <= steady || ($urandom_range(0, 99) >= 19);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_column(rsp_word);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_waveform_minmax_decimator: done, errors");
         $finish;
      end
   end

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic wmmd_pkg::req_word_type random_frame(logic last_one);
      wmmd_pkg::req_word_type w;
      w.left_sample  = pick_sample();
      w.right_sample = pick_sample();
      w.final_frame  = last_one;
      return w;
   endfunction

   // offer one frame word, with random gaps ahead of it
   task automatic send_frame(wmmd_pkg::req_word_type w);
      while (!steady && $urandom_range(0, 99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      sb.note_frame(w);
      items_sent++;
   endtask

   task automatic send_fields(logic [15:0] l, logic [15:0] r, logic last_one);
      wmmd_pkg::req_word_type w;
      w.left_sample  = l;
      w.right_sample = r;
      w.final_frame  = last_one;
      send_frame(w);
   endtask

   // wait until every expected word is out and the pipeline is empty
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_register(wmmd_pkg::csr_index_type idx, logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      sb.apply_register(idx, data);
   endtask

   // write the chosen view registers back to back
   task automatic program_view(logic [3:0] which, logic [31:0] spp, logic [23:0] scr,
                               logic [12:0] cols, logic st);
      if (which[0]) set_register(wmmd_pkg::CSR_SPP, spp);
      if (which[1]) set_register(wmmd_pkg::CSR_SCROLL, {8'd0, scr});
      if (which[2]) set_register(wmmd_pkg::CSR_COLUMNS, {19'd0, cols});
      if (which[3]) set_register(wmmd_pkg::CSR_STEREO, {31'd0, st});
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [3:0]        which;
      logic [31:0]       spp;
      logic [23:0]       scr;
      logic [12:0]       cols;
      logic              st;
      longint unsigned   view_frames;
      int                clip_len;
      logic              last_one;

      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset view: one frame per column, sample extremes, final with fill
      send_fields(16'h8000, 16'h7FFF, 1'b0);
      send_fields(16'h7FFF, 16'h8000, 1'b0);
      send_fields(16'h0000, 16'h0000, 1'b0);
      send_fields(16'hFFFF, 16'h0001, 1'b0);
      send_fields(16'h1234, 16'hEDCB, 1'b1);
      settle();

      // fractional spp, scrolled mono view, frames past the view, final after done
      program_view(4'hF, 32'h0002_8000, 24'd2, 13'd3, 1'b0);
      for (int i = 0; i < 11; i++) send_frame(random_frame(i == 10));
      settle();

      // final before the view, tiny spp and zero columns, then oversized count
      program_view(4'hF, 32'd100, 24'hFF_FFFF, 13'd0, 1'b1);
      send_fields(16'h8001, 16'h7FFE, 1'b1);
      settle();
      program_view(4'h5, 32'hFFFF_FFFF, 24'd0, 13'd5000, 1'b1);
      send_fields(16'h4000, 16'hC000, 1'b1);
      settle();

      // register change mid-clip leaves the current frame past the column end
      program_view(4'hF, 32'h000A_0000, 24'd0, 13'h1FFF, 1'b1);
      for (int i = 0; i < 4; i++) send_frame(random_frame(1'b0));
      settle();
      program_view(4'h1, wmmd_pkg::SPP_ONE, 24'd0, 13'd0, 1'b0);
      for (int i = 0; i < 3; i++) send_frame(random_frame(i == 2));

      // random clips under random views
      while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         settle();
         if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 2))
               0:       spp = 32'($urandom_range(0, 65535));
               1:       spp = 32'hFFFF_FFFF;
               default: spp = wmmd_pkg::SPP_ONE;
            endcase
            scr  = ($urandom_range(0, 2) == 0) ? 24'hFF_FFFF : 24'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
               0:       cols = 13'd0;
               1:       cols = wmmd_pkg::MAX_COLUMNS;
               2:       cols = 13'h1FFF;
               default: cols = 13'($urandom);
            endcase
         end else begin
            spp  = 32'($urandom_range(65536, 4 * 65536));
            scr  = 24'($urandom_range(0, 20));
            cols = 13'($urandom_range(1, 16));
         end
         st    = 1'($urandom);
         which = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'hF;
         program_view(which, spp, scr, cols, st);

         view_frames = 64'(sb.scroll)
                       + ((64'(sb.columns_used()) * 64'(sb.spp_used())) >> 16);
         clip_len = (view_frames + 4 > 120) ? $urandom_range(1, 120)
                                            : $urandom_range(1, int'(view_frames) + 4);
         for (int i = 0; i < clip_len; i++) begin
            // a long clean stretch, and two long receiver hold-offs
            steady <= (items_sent >= DIRECTED_ITEMS + 400)
                      && (items_sent < DIRECTED_ITEMS + 700);
            if (items_sent == DIRECTED_ITEMS + 200 || items_sent == DIRECTED_ITEMS + 900)
               holdoff_asked <= holdoff_asked + 1;
            if (i == clip_len - 1) last_one = ($urandom_range(0, 99) < 85);
            else                   last_one = ($urandom_range(0, 99) < 3);
            send_frame(random_frame(last_one));
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb_waveform_minmax_decimator: done, clean");
      end else begin
         $display("tb_waveform_minmax_decimator: done, errors");
      end
      $finish;
   end

endmodule
